[hw/rtl/dda_pkg.sv]
// Shared types, codes and defaults for the DDA line rasterizer.
package dda_pkg;

  localparam int DDA_FRAC_BITS  = 16;
  localparam int DDA_COORD_BITS = 11;
  localparam int SCREEN_BITS    = 10;
  localparam int VALUE_BITS     = 16;
  localparam int CFG_IDX_BITS   = 1;

  localparam logic [SCREEN_BITS-1:0] SCREEN_W_RESET = 10'd256;
  localparam logic [SCREEN_BITS-1:0] SCREEN_H_RESET = 10'd144;

  // op field codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } dda_state_e;

  typedef struct packed {
    logic load;        // latch a new line and seed the dividers
    logic div_step;    // one quotient bit per divider
    logic div_finish;  // write signed increments
    logic emit;        // produce one result and advance while steps remain
  } dda_cmd_t;

  typedef struct packed {
    logic load_zero;   // line on the input bus has zero length
    logic out_stall;   // output register full and not taken this cycle
  } dda_status_t;

endpackage

[hw/rtl/dda_div.sv]
// Radix-2 restoring divider lane: one quotient bit per step, remainder kept below divisor.
module dda_div
  import dda_pkg::*;
#(
  parameter int FRAC_BITS  = DDA_FRAC_BITS,
  parameter int COORD_BITS = DDA_COORD_BITS
) (
  input  logic                  clk_i,
  input  logic                  init_i,
  input  logic                  step_i,
  input  logic [COORD_BITS-1:0] mag_i,
  input  logic [COORD_BITS-1:0] divisor_i,
  output logic [FRAC_BITS:0]    quo_o
);

  logic [COORD_BITS:0]   rem_q, rem_d;
  logic [FRAC_BITS:0]    quo_q, quo_d;
  logic                  ge;
  logic [COORD_BITS:0]   diff;
  logic [COORD_BITS-1:0] rest;

  assign ge   = rem_q >= {1'b0, divisor_i};
  assign diff = rem_q - {1'b0, divisor_i};
  // rest is below the divisor, so it fits and its double fits the remainder
  assign rest = ge ? diff[COORD_BITS-1:0] : rem_q[COORD_BITS-1:0];

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    if (init_i) begin
      rem_d = {1'b0, mag_i};
      quo_d = '0;
    end else if (step_i) begin
      rem_d = {rest, 1'b0};
      quo_d = {quo_q[FRAC_BITS-1:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign quo_o = quo_q;

endmodule

[hw/rtl/dda_ctrl.sv]
// Controller: sequences loads through the divider and gates input acceptance.
module dda_ctrl
  import dda_pkg::*;
#(
  parameter int FRAC_BITS = DDA_FRAC_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  input  logic        op_i,
  input  dda_status_t status_i,
  output logic        s_tready,
  output dda_cmd_t    cmd_o
);

  localparam int CntW = $clog2(FRAC_BITS + 1);

  dda_state_e      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept;
  logic            last_iter;

  assign s_tready  = (state_q == ST_IDLE) && !status_i.out_stall;
  assign accept    = s_tvalid && s_tready;
  assign last_iter = cnt_q == CntW'(FRAC_BITS);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && op_i == OP_LOAD && !status_i.load_zero) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (last_iter) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cnt_d = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d            = '0;
        cmd_o.load       = accept && op_i == OP_LOAD;
        cmd_o.emit       = accept && op_i == OP_STEP;
      end
      ST_DIV: begin
        cmd_o.div_step   = 1'b1;
        cnt_d            = cnt_q + 1'b1;
      end
      ST_FIN:  cmd_o.div_finish = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

[hw/rtl/dda_datapath.sv]
// Datapath: line state, increment dividers, rounding, clipping and the output register.
module dda_datapath
  import dda_pkg::*;
#(
  parameter  int FRAC_BITS  = DDA_FRAC_BITS,
  parameter  int COORD_BITS = DDA_COORD_BITS,
  localparam int InW  = ((4 * COORD_BITS + VALUE_BITS + 7) / 8) * 8,
  localparam int OutW = ((2 * COORD_BITS + 1 + VALUE_BITS + 7) / 8) * 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dda_cmd_t                cmd_i,
  output dda_status_t             status_o,
  input  logic [InW-1:0]          s_tdata,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [SCREEN_BITS-1:0]  cfg_wdata_i,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [OutW-1:0]         m_tdata,
  output logic                    m_tuser,
  output logic                    m_tlast
);

  localparam int CB    = COORD_BITS;
  localparam int PosW  = CB + FRAC_BITS + 1;
  localparam int IncW  = FRAC_BITS + 2;
  localparam int CmpW  = CB + SCREEN_BITS;
  localparam int PadW  = OutW - (2 * CB + 1 + VALUE_BITS);
  localparam logic [PosW-1:0] Half   = PosW'(1) << (FRAC_BITS - 1);
  localparam logic [PosW-1:0] HalfM1 = Half - PosW'(1);

  // input unpack
  logic [CB-1:0]         sx, sy, ex, ey;
  logic [VALUE_BITS-1:0] in_value;
  assign sx       = s_tdata[CB-1:0];
  assign sy       = s_tdata[2*CB-1:CB];
  assign ex       = s_tdata[3*CB-1:2*CB];
  assign ey       = s_tdata[4*CB-1:3*CB];
  assign in_value = s_tdata[4*CB+VALUE_BITS-1:4*CB];

  logic [CB:0]   dx, dy, ndx, ndy;
  logic [CB-1:0] ax, ay, steps;
  assign dx    = {ex[CB-1], ex} - {sx[CB-1], sx};
  assign dy    = {ey[CB-1], ey} - {sy[CB-1], sy};
  assign ndx   = ~dx + 1'b1;
  assign ndy   = ~dy + 1'b1;
  assign ax    = dx[CB] ? ndx[CB-1:0] : dx[CB-1:0];
  assign ay    = dy[CB] ? ndy[CB-1:0] : dy[CB-1:0];
  assign steps = (ax > ay) ? ax : ay;

  // line state
  logic [PosW-1:0]       pos_x_q, pos_y_q;
  logic [IncW-1:0]       inc_x_q, inc_y_q;
  logic [CB-1:0]         steps_left_q;
  logic [VALUE_BITS-1:0] held_q;
  logic                  neg_x_q, neg_y_q;
  logic [SCREEN_BITS-1:0] width_q, height_q;

  logic [FRAC_BITS:0] quo_x, quo_y;
  logic [IncW-1:0]    qx_ext, qy_ext;

  dda_div #(.FRAC_BITS(FRAC_BITS), .COORD_BITS(CB)) u_div_x (
    .clk_i     (clk_i),
    .init_i    (cmd_i.load),
    .step_i    (cmd_i.div_step),
    .mag_i     (ax),
    .divisor_i (steps_left_q),
    .quo_o     (quo_x)
  );

  dda_div #(.FRAC_BITS(FRAC_BITS), .COORD_BITS(CB)) u_div_y (
    .clk_i     (clk_i),
    .init_i    (cmd_i.load),
    .step_i    (cmd_i.div_step),
    .mag_i     (ay),
    .divisor_i (steps_left_q),
    .quo_o     (quo_y)
  );

  assign qx_ext = {1'b0, quo_x};
  assign qy_ext = {1'b0, quo_y};

  // round half away from zero: negative values take half minus one before the floor shift
  logic [PosW-1:0] rnd_x, rnd_y;
  logic [CB:0]     rx, ry;
  logic            vis;
  assign rnd_x = pos_x_q + (pos_x_q[PosW-1] ? HalfM1 : Half);
  assign rnd_y = pos_y_q + (pos_y_q[PosW-1] ? HalfM1 : Half);
  assign rx    = rnd_x[PosW-1:FRAC_BITS];
  assign ry    = rnd_y[PosW-1:FRAC_BITS];
  assign vis   = !rx[CB] && !ry[CB] &&
                 (CmpW'(rx[CB-1:0]) < CmpW'(width_q)) &&
                 (CmpW'(ry[CB-1:0]) < CmpW'(height_q));

  logic [PosW-1:0] inc_x_ext, inc_y_ext;
  assign inc_x_ext = {{(PosW-IncW){inc_x_q[IncW-1]}}, inc_x_q};
  assign inc_y_ext = {{(PosW-IncW){inc_y_q[IncW-1]}}, inc_y_q};

  logic active;
  assign active = steps_left_q != '0;

  // output register
  logic                  out_valid_q;
  logic                  res_valid_q, res_last_q, res_vis_q;
  logic [CB-1:0]         res_x_q, res_y_q;
  logic [VALUE_BITS-1:0] res_value_q;

  assign status_o.load_zero = steps == '0;
  assign status_o.out_stall = out_valid_q && !m_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_left_q <= '0;
      out_valid_q  <= 1'b0;
      width_q      <= SCREEN_W_RESET;
      height_q     <= SCREEN_H_RESET;
    end else begin
      if (cmd_i.load) begin
        steps_left_q <= steps;
      end else if (cmd_i.emit && active) begin
        steps_left_q <= steps_left_q - 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (m_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SCREEN_WIDTH:  width_q  <= cfg_wdata_i;
          CFG_SCREEN_HEIGHT: height_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_x_q <= {sx[CB-1], sx, {FRAC_BITS{1'b0}}};
      pos_y_q <= {sy[CB-1], sy, {FRAC_BITS{1'b0}}};
      neg_x_q <= dx[CB];
      neg_y_q <= dy[CB];
      held_q  <= in_value;
    end else if (cmd_i.emit && active) begin
      pos_x_q <= pos_x_q + inc_x_ext;
      pos_y_q <= pos_y_q + inc_y_ext;
    end
    if (cmd_i.div_finish) begin
      inc_x_q <= neg_x_q ? (~qx_ext + 1'b1) : qx_ext;
      inc_y_q <= neg_y_q ? (~qy_ext + 1'b1) : qy_ext;
    end
    if (cmd_i.emit) begin
      res_valid_q <= active;
      res_x_q     <= active ? rx[CB-1:0] : '0;
      res_y_q     <= active ? ry[CB-1:0] : '0;
      res_vis_q   <= active && vis;
      res_value_q <= active ? held_q : '0;
      res_last_q  <= steps_left_q == CB'(1);
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tuser  = res_valid_q;
  assign m_tlast  = res_last_q;
  assign m_tdata  = {{PadW{1'b0}}, res_value_q, res_vis_q, res_y_q, res_x_q};

endmodule

[hw/rtl/dda_line_rasterizer_unit.sv]
// Top level of the DDA line rasterizer: controller, datapath and port packing.
//
//  channel  direction  tdata (low bit up)                              tuser      tlast
//  s_*      in         start_x, start_y, end_x, end_y, pixel_value     op         -
//  m_*      out        pixel_x, pixel_y, visible, write_value          valid_res  last
//  cfg_*    in         cfg_idx_i 0 screen_width, 1 screen_height, cfg_wdata_i value
//
// A step request's result sits in the output register the next cycle.
// A load of a line with nonzero length runs the bit-serial increment dividers through
// FRAC_BITS+1 quotient bits and then signs the increments before the next input is taken.
// A stalled output holds the result and drops s_tready until it is taken.
// Reset clears the line (steps left zero) and restores the default screen size.
module dda_line_rasterizer_unit
  import dda_pkg::*;
#(
  parameter  int FRAC_BITS  = DDA_FRAC_BITS,
  parameter  int COORD_BITS = DDA_COORD_BITS,
  localparam int InW  = ((4 * COORD_BITS + VALUE_BITS + 7) / 8) * 8,
  localparam int OutW = ((2 * COORD_BITS + 1 + VALUE_BITS + 7) / 8) * 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [InW-1:0]          s_tdata,   // start_x, start_y, end_x, end_y, pixel_value
  input  logic                    s_tuser,   // op
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [OutW-1:0]         m_tdata,   // pixel_x, pixel_y, visible, write_value
  output logic                    m_tuser,   // valid_res
  output logic                    m_tlast,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [SCREEN_BITS-1:0]  cfg_wdata_i
);

  dda_cmd_t    cmd;
  dda_status_t status;

  dda_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .op_i     (s_tuser),
    .status_i (status),
    .s_tready (s_tready),
    .cmd_o    (cmd)
  );

  dda_datapath #(.FRAC_BITS(FRAC_BITS), .COORD_BITS(COORD_BITS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .s_tdata     (s_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

endmodule

[hw/rtl/dda_checker.sv]
// Port-level checks for the DDA line rasterizer, bound to the top level.
module dda_checker
  import dda_pkg::*;
#(
  parameter  int COORD_BITS = DDA_COORD_BITS,
  localparam int InW  = ((4 * COORD_BITS + VALUE_BITS + 7) / 8) * 8,
  localparam int OutW = ((2 * COORD_BITS + 1 + VALUE_BITS + 7) / 8) * 8
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    s_tvalid,
  input logic                    s_tready,
  input logic [InW-1:0]          s_tdata,
  input logic                    s_tuser,
  input logic                    m_tvalid,
  input logic                    m_tready,
  input logic [OutW-1:0]         m_tdata,
  input logic                    m_tuser,
  input logic                    m_tlast
);

  localparam int CB = COORD_BITS;

  logic long_load;
  assign long_load = s_tvalid && s_tready && s_tuser == OP_LOAD &&
                     (s_tdata[CB-1:0] != s_tdata[3*CB-1:2*CB] ||
                      s_tdata[2*CB-1:CB] != s_tdata[4*CB-1:3*CB]);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                              $stable(m_tlast))
    else $error("stalled result changed");

  // a step with no line answers with an all-zero transaction
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tuser |-> m_tdata == '0 && !m_tlast)
    else $error("empty result carries data");

  // a visible pixel has nonnegative coordinates
  a_vis_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tdata[2*CB] |-> m_tuser && !m_tdata[CB-1] && !m_tdata[2*CB-1])
    else $error("visible pixel off screen");

  // a line of nonzero length occupies the divider
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    long_load |=> !s_tready)
    else $error("input accepted during divide");

endmodule

bind dda_line_rasterizer_unit dda_checker #(.COORD_BITS(COORD_BITS)) u_dda_checker (.*);
